/* src/pes_pkg.sv */
`default_nettype none
package pes_pkg;
  localparam int PriorityLevels = 4;
  localparam int SlotsPerLevel  = 2;
  localparam int QueueDepth     = 4;
  localparam int TimerEntries   = 8;
  localparam int NumSlots       = PriorityLevels * SlotsPerLevel;
  localparam int SlotW          = 3;
  localparam int QPtrW          = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QFillW         = $clog2(QueueDepth + 1);
  localparam int TmrW           = (TimerEntries > 1) ? $clog2(TimerEntries) : 1;
  localparam int StoreDepth     = NumSlots * QueueDepth;
  localparam int StoreAw        = $clog2(StoreDepth);

  typedef enum logic [1:0] {
    OP_POST     = 2'd0,
    OP_TICK     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  task_slot;
    logic [15:0] event_code;
    logic [31:0] data_word;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        dispatch_valid;
    logic [2:0]  dispatch_slot;
    logic [15:0] dispatch_event;
    logic [31:0] dispatch_data;
    logic [3:0]  expired_count;
  } out_item_t;
endpackage
`default_nettype wire

/* src/pes_if.sv */
`default_nettype none
interface pes_in_if;
  logic               valid;
  logic               ready;
  pes_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pes_out_if;
  logic               valid;
  logic               ready;
  pes_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pes_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/priority_event_scheduler_with_timers_top.sv */
// channel | dir | payload
// in      | in  | opcode, task_slot, event_code, data_word, delay_ticks
// out     | out | status, dispatch_valid/slot/event/data, expired_count
// cfg     | in  | task_enable_mask (8 bits)
// Each op ends in S_DONE. Post: S_POST; dispatch: S_SCAN per slot, then S_DOUT
// if one is found; tick: S_TLOOK, S_TENQ on expiry and S_TNEXT per timer entry
// (8 entries), one entry at a time over the single event-store port. Reset is
// synchronous, no clearing pass needed. in is ready whenever the sequencer is
// idle; a result stalled on out holds the next item in its done state.
`default_nettype none
module priority_event_scheduler_with_timers_top (
  input  wire logic  clk,
  input  wire logic  rst,
  pes_in_if.sink     in,
  pes_out_if.source  out,
  pes_cfg_if.sink    cfg
);
  typedef enum logic [3:0] {
    S_IDLE, S_POST, S_SCAN, S_DRD, S_DOUT, S_TLOOK, S_TENQ, S_TNEXT, S_DONE
  } state_t;

  state_t state;
  pes_pkg::in_item_t  item;
  pes_pkg::out_item_t res;
  pes_pkg::out_item_t res_init;
  logic [7:0] mask;
  logic [47:0] store [pes_pkg::StoreDepth];
  logic [47:0] rd_data;
  logic [pes_pkg::QPtrW-1:0]  qhead [pes_pkg::NumSlots];
  logic [pes_pkg::QFillW-1:0] qfill [pes_pkg::NumSlots];
  logic [pes_pkg::TimerEntries-1:0] tbusy;
  logic [63:0] tpay [pes_pkg::TimerEntries];
  logic [2:0]  ttgt [pes_pkg::TimerEntries];
  logic [pes_pkg::TmrW:0] tidx;
  logic [pes_pkg::TmrW-1:0] ti;
  logic [3:0] scan;
  logic [15:0] dly;
  logic [2:0] sl;
  logic [pes_pkg::QPtrW-1:0] tail;
  logic [pes_pkg::TmrW-1:0] free_idx;
  logic free_any;
  logic slot_ok;
  logic [3:0] freed;

  assign cfg.ready = (state == S_IDLE);
  assign in.ready  = (state == S_IDLE);
  assign ti = tidx[pes_pkg::TmrW-1:0];

  function automatic logic en_ok(input logic [7:0] m, input logic [2:0] s);
    return (32'(s) < pes_pkg::NumSlots) && m[s];
  endfunction

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = pes_pkg::TimerEntries - 1; i >= 0; i--) begin
      if (!tbusy[i]) begin
        free_any = 1'b1;
        free_idx = pes_pkg::TmrW'(i);
      end
    end
  end

  always_comb begin
    res_init = '0;
    res_init.status = (in.payload.opcode == pes_pkg::OP_UNUSED);
  end

  // target slot of current enqueue (post or timer expiry)
  assign sl = (state == S_POST) ? item.task_slot : ttgt[ti];
  assign slot_ok = en_ok(mask, sl) && (32'(qfill[sl[pes_pkg::SlotW-1:0]]) < pes_pkg::QueueDepth);
  assign tail = pes_pkg::QPtrW'((32'(qhead[sl]) + 32'(qfill[sl])) % pes_pkg::QueueDepth);
  assign dly = tpay[ti][63:48];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      mask <= '0;
      tbusy <= '0;
      for (int s = 0; s < pes_pkg::NumSlots; s++) begin
        qhead[s] <= '0;
        qfill[s] <= '0;
      end
    end else begin
      if (state == S_DONE && (!out.valid || out.ready)) out.valid <= 1'b1;
      else if (out.valid && out.ready) out.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg.valid) mask <= cfg.payload;
          if (in.valid && in.ready) begin
            item <= in.payload;
            res <= res_init;
            scan <= '0;
            tidx <= '0;
            freed <= '0;
            unique case (pes_pkg::opcode_t'(in.payload.opcode))
              pes_pkg::OP_POST:     state <= S_POST;
              pes_pkg::OP_TICK:     state <= S_TLOOK;
              pes_pkg::OP_DISPATCH: state <= S_SCAN;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_POST: begin
          if (item.delay_ticks == '0) begin
            if (slot_ok) begin
              store[pes_pkg::StoreAw'(32'(sl) * pes_pkg::QueueDepth + 32'(tail))] <=
                {item.event_code, item.data_word};
              qfill[sl] <= qfill[sl] + 1'b1;
            end else res.status <= 1'b1;
          end else begin
            if (en_ok(mask, item.task_slot) && free_any) begin
              tbusy[free_idx] <= 1'b1;
              ttgt[free_idx] <= item.task_slot;
              tpay[free_idx] <= {item.delay_ticks, item.event_code, item.data_word};
            end else res.status <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (scan == 4'(pes_pkg::NumSlots)) state <= S_DONE;
          else if (qfill[scan[2:0]] != '0) begin
            rd_data <= store[pes_pkg::StoreAw'(32'(scan[2:0]) * pes_pkg::QueueDepth
                                               + 32'(qhead[scan[2:0]]))];
            qhead[scan[2:0]] <= pes_pkg::QPtrW'((32'(qhead[scan[2:0]]) + 1) % pes_pkg::QueueDepth);
            qfill[scan[2:0]] <= qfill[scan[2:0]] - 1'b1;
            state <= S_DOUT;
          end else scan <= scan + 1'b1;
        end
        S_DOUT: begin
          res.dispatch_valid <= 1'b1;
          res.dispatch_slot <= scan[2:0];
          res.dispatch_event <= rd_data[47:32];
          res.dispatch_data <= rd_data[31:0];
          state <= S_DONE;
        end
        S_TLOOK: begin
          if (tidx == (pes_pkg::TmrW+1)'(pes_pkg::TimerEntries)) begin
            res.expired_count <= freed;
            state <= S_DONE;
          end else if (tbusy[ti]) begin
            if (dly != '0) tpay[ti][63:48] <= dly - 1'b1;
            state <= (dly <= 16'd1) ? S_TENQ : S_TNEXT;
          end else state <= S_TNEXT;
        end
        S_TENQ: begin
          if (slot_ok) begin
            store[pes_pkg::StoreAw'(32'(sl) * pes_pkg::QueueDepth + 32'(tail))] <=
              tpay[ti][47:0];
            qfill[sl] <= qfill[sl] + 1'b1;
            tbusy[ti] <= 1'b0;
            if (freed != 4'd15) freed <= freed + 1'b1;
          end
          state <= S_TNEXT;
        end
        S_TNEXT: begin
          tidx <= tidx + 1'b1;
          state <= S_TLOOK;
        end
        S_DONE: begin
          if (!out.valid || out.ready) begin
            out.payload <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in.ready) else $error("ready while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(qfill[0]) <= pes_pkg::QueueDepth) else $error("fill overflow");
  a_dispatch_only: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.payload.dispatch_valid) |-> !out.payload.status)
    else $error("bad dispatch result");
`endif
endmodule
`default_nettype wire

/* bench/tb_priority_event_scheduler_with_timers_top.sv */
module tb_priority_event_scheduler_with_timers_top;
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  pes_in_if  in_ch();
  pes_out_if out_ch();
  pes_cfg_if cfg_ch();

  priority_event_scheduler_with_timers_top dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
  );

  // scheduler shadow state
  logic [7:0]  slot_mask;
  logic [47:0] slot_queue [pes_pkg::NumSlots][pes_pkg::QueueDepth];
  int          q_head [pes_pkg::NumSlots];
  int          q_fill [pes_pkg::NumSlots];
  logic        tmr_busy [pes_pkg::TimerEntries];
  logic [15:0] tmr_delay [pes_pkg::TimerEntries];
  logic [47:0] tmr_event [pes_pkg::TimerEntries];
  logic [2:0]  tmr_slot [pes_pkg::TimerEntries];

  pes_pkg::out_item_t expected_results [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_out = 1'b0;
  bit failed = 1'b0;

  function automatic bit slot_on(logic [2:0] s);
    return (int'(s) < pes_pkg::NumSlots) && slot_mask[s];
  endfunction

  function automatic bit push_event(logic [2:0] s, logic [47:0] ev);
    if (!slot_on(s) || q_fill[s] >= pes_pkg::QueueDepth) return 1'b0;
    slot_queue[s][(q_head[s] + q_fill[s]) % pes_pkg::QueueDepth] = ev;
    q_fill[s]++;
    return 1'b1;
  endfunction

  function automatic pes_pkg::out_item_t schedule_step(pes_pkg::in_item_t it);
    pes_pkg::out_item_t r;
    int freed;
    bit ok;
    r = '0;
    freed = 0;
    ok = 1'b0;
    case (pes_pkg::opcode_t'(it.opcode))
      pes_pkg::OP_POST: begin
        if (it.delay_ticks == 0) begin
          ok = push_event(it.task_slot, {it.event_code, it.data_word});
        end else if (slot_on(it.task_slot)) begin
          for (int i = 0; i < pes_pkg::TimerEntries; i++) begin
            if (!ok && !tmr_busy[i]) begin
              tmr_busy[i] = 1'b1;
              tmr_slot[i] = it.task_slot;
              tmr_delay[i] = it.delay_ticks;
              tmr_event[i] = {it.event_code, it.data_word};
              ok = 1'b1;
            end
          end
        end
        r.status = !ok;
      end
      pes_pkg::OP_TICK: begin
        for (int i = 0; i < pes_pkg::TimerEntries; i++) begin
          if (tmr_busy[i]) begin
            if (tmr_delay[i] > 0) tmr_delay[i]--;
            if (tmr_delay[i] == 0 && push_event(tmr_slot[i], tmr_event[i])) begin
              tmr_busy[i] = 1'b0;
              freed++;
            end
          end
        end
        r.expired_count = (freed > 15) ? 4'd15 : freed[3:0];
      end
      pes_pkg::OP_DISPATCH: begin
        for (int s = 0; s < pes_pkg::NumSlots; s++) begin
          if (!r.dispatch_valid && q_fill[s] != 0) begin
            r.dispatch_valid = 1'b1;
            r.dispatch_slot = s[2:0];
            {r.dispatch_event, r.dispatch_data} = slot_queue[s][q_head[s]];
            q_head[s] = (q_head[s] + 1) % pes_pkg::QueueDepth;
            q_fill[s]--;
          end
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // valid stays high after an accept until the next item or an idle cycle
  task automatic send_item(pes_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(schedule_step(it));
  endtask

  task automatic stop_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_mask(logic [7:0] m);
    stop_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    slot_mask = m;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic pes_pkg::in_item_t make_item(pes_pkg::opcode_t op, logic [2:0] s,
                                                  logic [15:0] ev, logic [31:0] d,
                                                  logic [15:0] dl);
    pes_pkg::in_item_t it;
    it.opcode = op;
    it.task_slot = s;
    it.event_code = ev;
    it.data_word = d;
    it.delay_ticks = dl;
    return it;
  endfunction

  function automatic pes_pkg::in_item_t random_item();
    int pick;
    pes_pkg::in_item_t it;
    pick = $urandom_range(99);
    it = make_item(pes_pkg::OP_POST, 3'($urandom_range(7)), 16'($urandom), $urandom,
                   16'd0);
    if (pick < 30) it.delay_ticks = 16'd0;
    else if (pick < 42) it.delay_ticks = 16'($urandom_range(1, 4));
    else if (pick < 45) it.delay_ticks = 16'($urandom);
    else if (pick < 70) it.opcode = pes_pkg::OP_TICK;
    else if (pick < 97) it.opcode = pes_pkg::OP_DISPATCH;
    else it.opcode = pes_pkg::OP_UNUSED;
    if (pick >= 45 && $urandom_range(3) == 0) it.delay_ticks = 16'($urandom);
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_out && ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          failed = 1'b1;
          if (mismatches < 10) $display("unexpected result %h", out_ch.payload);
          mismatches++;
        end else if (out_ch.payload !== expected_results[0]) begin
          failed = 1'b1;
          if (mismatches < 10)
            $display("mismatch: expected %h actual %h", expected_results[0],
                     out_ch.payload);
          mismatches++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    write_mask(8'hFF);
    send_item(make_item(pes_pkg::OP_DISPATCH, 3'd0, 16'd0, 32'd0, 16'd0));
    for (int i = 0; i < 5; i++)
      send_item(make_item(pes_pkg::OP_POST, 3'd7, 16'(16'hFFFF - i), 32'hFFFF_FFFF - i,
                          16'd0));
    send_item(make_item(pes_pkg::OP_POST, 3'd0, 16'h0000, 32'h0, 16'd0));
    for (int i = 0; i < 9; i++)
      send_item(make_item(pes_pkg::OP_POST, 3'(i), 16'h5A5A, 32'hA5A5_0000 + i, 16'd1));
    send_item(make_item(pes_pkg::OP_TICK, 3'd0, 16'd0, 32'd0, 16'd0));
    send_item(make_item(pes_pkg::OP_UNUSED, 3'd5, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    for (int i = 0; i < 6; i++)
      send_item(make_item(pes_pkg::OP_DISPATCH, 3'd0, 16'd0, 32'd0, 16'd0));
    write_mask(8'h00);
    send_item(make_item(pes_pkg::OP_POST, 3'd2, 16'd1, 32'd1, 16'd0));
    send_item(make_item(pes_pkg::OP_POST, 3'd2, 16'd1, 32'd1, 16'hFFFF));
    send_item(make_item(pes_pkg::OP_TICK, 3'd0, 16'd0, 32'd0, 16'd0));
    send_item(make_item(pes_pkg::OP_DISPATCH, 3'd0, 16'd0, 32'd0, 16'd0));
  endtask

  task automatic test_random_phase(int n, int s_pct, int r_pct, logic [7:0] m);
    write_mask(m);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_out = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_item(random_item());
    join
    stop_input();
    while (expected_results.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_item(random_item());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    slot_mask = '0;
    for (int s = 0; s < pes_pkg::NumSlots; s++) begin
      q_head[s] = 0;
      q_fill[s] = 0;
    end
    for (int i = 0; i < pes_pkg::TimerEntries; i++) tmr_busy[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(160, 0, 0, 8'hFF);
    test_random_phase(150, 53, 0, 8'h5A);
    test_random_phase(150, 0, 53, 8'hA5);
    test_random_phase(150, 12, 12, 8'hFF);
    test_backpressure();
    stop_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
src/pes_pkg.sv
src/pes_if.sv
src/priority_event_scheduler_with_timers_top.sv
bench/tb_priority_event_scheduler_with_timers_top.sv
